// File: sv/bqlp_pkg.sv
// Shared types, widths and constants for the multichannel biquad low-pass filter.
// No dependencies; every other file of the block imports this package.

package bqlp_pkg;

    // fixed field widths
    localparam int CH_W       = 2;
    localparam int COEF_W     = 24;
    localparam int HIST_W     = 32;
    localparam int HIST_FRAC  = 12;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;

    // parameter defaults
    localparam int CHANNELS_DEF       = 3;
    localparam int SAMPLE_BITS_DEF    = 12;
    localparam int COEF_FRAC_BITS_DEF = 22;

    // saturation limits of the output history (signed Q20.12)
    localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
    localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

    // half an output lsb, for round half up
    localparam logic [HIST_W:0] ROUND_HALF = (HIST_W+1)'(1) << (HIST_FRAC - 1);

    // coefficient register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } reg_idx_t;

    // coefficient reset values, signed Q2.22
    localparam logic signed [COEF_W-1:0] B0_RST = 24'sd282928;
    localparam logic signed [COEF_W-1:0] B1_RST = 24'sd565856;
    localparam logic signed [COEF_W-1:0] B2_RST = 24'sd282928;
    localparam logic signed [COEF_W-1:0] A1_RST = -24'sd4794008;
    localparam logic signed [COEF_W-1:0] A2_RST = 24'sd1731417;

    // the shared coefficient set
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_t;

endpackage

// File: sv/bqlp_if.sv
// Valid/ready channel interfaces of the biquad filter: samples, results, coefficient writes.
// Depends on bqlp_pkg.

interface bqlp_sample_if #(
    parameter int SAMPLE_BITS = bqlp_pkg::SAMPLE_BITS_DEF
);
    import bqlp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CH_W-1:0]        channel;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface bqlp_result_if;
    import bqlp_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_channel;
    logic [OUT_W-1:0] filtered;

    modport source (output valid, output out_channel, output filtered, input ready);
    modport sink   (input valid, input out_channel, input filtered, output ready);
endinterface

interface bqlp_cfg_if;
    import bqlp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/bqlp_coef_regs.sv
// Coefficient register file, written through the configuration channel.
// Depends on bqlp_pkg and bqlp_cfg_if.

module bqlp_coef_regs (
    input  logic            clk,
    input  logic            rst_n,
    bqlp_cfg_if.sink        cfg,
    output bqlp_pkg::coef_t coef
);
    import bqlp_pkg::*;

    coef_t coef_reg;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign coef      = coef_reg;

    // register write decode, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= B0_RST;
            coef_reg.b1 <= B1_RST;
            coef_reg.b2 <= B2_RST;
            coef_reg.a1 <= A1_RST;
            coef_reg.a2 <= A2_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_B0:  coef_reg.b0 <= cfg.data;
                REG_B1:  coef_reg.b1 <= cfg.data;
                REG_B2:  coef_reg.b2 <= cfg.data;
                REG_A1:  coef_reg.a1 <= cfg.data;
                REG_A2:  coef_reg.a2 <= cfg.data;
                default: ;
            endcase
        end
    end
endmodule

// File: sv/bqlp_history.sv
// Per-channel filter history: two past samples and two past outputs for each channel.
// Depends on bqlp_pkg.

module bqlp_history #(
    parameter int CHANNELS    = bqlp_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = bqlp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bqlp_pkg::CH_W-1:0]           ch,
    input  logic                                wr_en,
    input  logic [SAMPLE_BITS-1:0]              wr_x,
    input  logic signed [bqlp_pkg::HIST_W-1:0]  wr_y,
    output logic [SAMPLE_BITS-1:0]              x1,
    output logic [SAMPLE_BITS-1:0]              x2,
    output logic signed [bqlp_pkg::HIST_W-1:0]  y1,
    output logic signed [bqlp_pkg::HIST_W-1:0]  y2
);
    import bqlp_pkg::*;

    logic [SAMPLE_BITS-1:0]   x1_reg [CHANNELS];
    logic [SAMPLE_BITS-1:0]   x2_reg [CHANNELS];
    logic signed [HIST_W-1:0] y1_reg [CHANNELS];
    logic signed [HIST_W-1:0] y2_reg [CHANNELS];

    // select the history of the addressed channel
    always_comb
    begin
        x1 = '0;
        x2 = '0;
        y1 = '0;
        y2 = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (int'(ch) == c)
            begin
                x1 = x1_reg[c];
                x2 = x2_reg[c];
                y1 = y1_reg[c];
                y2 = y2_reg[c];
            end
        end
    end

    // shift the new sample and output into the addressed channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                x1_reg[c] <= '0;
                x2_reg[c] <= '0;
                y1_reg[c] <= '0;
                y2_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (wr_en && int'(ch) == c)
                begin
                    x2_reg[c] <= x1_reg[c];
                    x1_reg[c] <= wr_x;
                    y2_reg[c] <= y1_reg[c];
                    y1_reg[c] <= wr_y;
                end
            end
        end
    end
endmodule

// File: sv/bqlp_arith.sv
// Biquad arithmetic: five products, exact sum, rounding to Q20.12, output conversion.
// Depends on bqlp_pkg.

module bqlp_arith #(
    parameter int SAMPLE_BITS    = bqlp_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqlp_pkg::COEF_FRAC_BITS_DEF
) (
    input  bqlp_pkg::coef_t                     coef,
    input  logic [SAMPLE_BITS-1:0]              x,
    input  logic [SAMPLE_BITS-1:0]              x1,
    input  logic [SAMPLE_BITS-1:0]              x2,
    input  logic signed [bqlp_pkg::HIST_W-1:0]  y1,
    input  logic signed [bqlp_pkg::HIST_W-1:0]  y2,
    output logic signed [bqlp_pkg::HIST_W-1:0]  y_new,
    output logic [bqlp_pkg::OUT_W-1:0]          filtered
);
    import bqlp_pkg::*;

    localparam int XP_W  = COEF_W + SAMPLE_BITS + 1;
    localparam int YP_W  = COEF_W + HIST_W;
    localparam int M1    = (XP_W + HIST_FRAC > YP_W) ? XP_W + HIST_FRAC : YP_W;
    localparam int M2    = (M1 > COEF_FRAC_BITS + HIST_W + 1) ? M1
                         : COEF_FRAC_BITS + HIST_W + 1;
    localparam int ACC_W = M2 + 3;
    localparam int SH_W  = ACC_W - COEF_FRAC_BITS;
    localparam int RI_W  = HIST_W + 1 - HIST_FRAC;

    logic signed [XP_W-1:0]  p0;
    logic signed [XP_W-1:0]  p1;
    logic signed [XP_W-1:0]  p2;
    logic signed [YP_W-1:0]  q1;
    logic signed [YP_W-1:0]  q2;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rnd;
    logic [SH_W-1:0]         ysh;
    logic                    ovf;
    logic [HIST_W:0]         rsum;
    logic [RI_W-1:0]         rint;
    logic                    sat;

    // products, samples taken as unsigned
    assign p0 = $signed(coef.b0) * $signed({1'b0, x});
    assign p1 = $signed(coef.b1) * $signed({1'b0, x1});
    assign p2 = $signed(coef.b2) * $signed({1'b0, x2});
    assign q1 = $signed(coef.a1) * y1;
    assign q2 = $signed(coef.a2) * y2;

    // exact sum, samples scaled to the history's fraction
    assign acc = (ACC_W'(p0) <<< HIST_FRAC) + (ACC_W'(p1) <<< HIST_FRAC)
               + (ACC_W'(p2) <<< HIST_FRAC) - ACC_W'(q1) - ACC_W'(q2);

    // round half up to Q20.12, floor shift
    assign rnd = acc + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
    assign ysh = rnd[ACC_W-1:COEF_FRAC_BITS];

    // saturate to the signed history range
    assign ovf   = !((&ysh[SH_W-1:HIST_W-1]) || !(|ysh[SH_W-1:HIST_W-1]));
    assign y_new = ovf ? (ysh[SH_W-1] ? HIST_MIN : HIST_MAX) : ysh[HIST_W-1:0];

    // output: clamp negatives, round to integer, saturate high
    assign rsum = {1'b0, y_new} + ROUND_HALF;
    assign rint = rsum[HIST_W:HIST_FRAC];
    assign sat  = |rint[RI_W-1:OUT_W];

    always_comb
    begin
        priority if (y_new[HIST_W-1])
            filtered = '0;
        else if (sat)
            filtered = '1;
        else
            filtered = rint[OUT_W-1:0];
    end
endmodule

// File: sv/biquad_lowpass_multichannel.sv
// Top level of the multichannel biquad low-pass filter (direct form I, fixed point).
// Depends on bqlp_pkg, the bqlp interfaces, bqlp_coef_regs, bqlp_history, bqlp_arith.

// Accepts one channel-tagged sample per clock cycle while the result sink keeps up, with
// no gaps even when the same channel repeats, and returns one result per sample in order.
// An accepted sample waits in the input register and moves into the result register once
// that register is free. The result register holds a result while the sink stalls. The
// input side keeps taking samples while the input register is empty or the result
// register is free or being emptied, so one more sample waits behind a stalled result.
// The cycle is set by the path from the per-channel history registers through the five
// coefficient products, their sum and the rounding back into the history registers.
// Samples on channels at or above CHANNELS leave every history untouched and return zero.
// Coefficient writes are always accepted and should be made while no sample is in flight.

module biquad_lowpass_multichannel #(
    parameter int CHANNELS       = bqlp_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS    = bqlp_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqlp_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    bqlp_sample_if.sink  smp,
    bqlp_result_if.source res,
    bqlp_cfg_if.sink     cfg
);
    import bqlp_pkg::*;

    coef_t                  coef;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [CH_W-1:0]        s1_ch_reg;
    logic [SAMPLE_BITS-1:0] s1_x_reg;
    logic                   s2_valid_reg;
    logic                   s2_valid_next;
    logic [CH_W-1:0]        s2_ch_reg;
    logic [OUT_W-1:0]       s2_filt_reg;
    logic                   s2_free;
    logic                   s1_adv;
    logic                   in_take;
    logic                   in_range;
    logic [SAMPLE_BITS-1:0] x1;
    logic [SAMPLE_BITS-1:0] x2;
    logic signed [HIST_W-1:0] y1;
    logic signed [HIST_W-1:0] y2;
    logic signed [HIST_W-1:0] y_new;
    logic [OUT_W-1:0]       filt;

    // coefficient registers
    bqlp_coef_regs u_coef (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coef  (coef)
    );

    // per-channel history, updated when the input stage hands over
    bqlp_history #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .ch    (s1_ch_reg),
        .wr_en (s1_adv && in_range),
        .wr_x  (s1_x_reg),
        .wr_y  (y_new),
        .x1    (x1),
        .x2    (x2),
        .y1    (y1),
        .y2    (y2)
    );

    // filter arithmetic
    bqlp_arith #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_arith (
        .coef     (coef),
        .x        (s1_x_reg),
        .x1       (x1),
        .x2       (x2),
        .y1       (y1),
        .y2       (y2),
        .y_new    (y_new),
        .filtered (filt)
    );

    // handshake between input and result stages
    assign in_range  = int'(s1_ch_reg) < CHANNELS;
    assign s2_free   = !s2_valid_reg || res.ready;
    assign s1_adv    = s1_valid_reg && s2_free;
    assign smp.ready = !s1_valid_reg || s2_free;
    assign in_take   = smp.valid && smp.ready;

    // stage valid next state
    always_comb
    begin
        priority if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        priority if (s1_adv)
            s2_valid_next = 1'b1;
        else if (res.ready)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;
    end

    // stage valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // input and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_ch_reg <= smp.channel;
            s1_x_reg  <= smp.sample;
        end
        if (s1_adv)
        begin
            s2_ch_reg   <= s1_ch_reg;
            s2_filt_reg <= in_range ? filt : '0;
        end
    end

    // result request
    assign res.valid       = s2_valid_reg;
    assign res.out_channel = s2_ch_reg;
    assign res.filtered    = s2_filt_reg;
endmodule

// File: sv/bqlp_checker.sv
// Port-level checks for the multichannel biquad filter, bound to the top level.
// Depends on bqlp_pkg and biquad_lowpass_multichannel.

module bqlp_checker #(
    parameter int CHANNELS = bqlp_pkg::CHANNELS_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [bqlp_pkg::CH_W-1:0]  out_channel,
    input logic [bqlp_pkg::OUT_W-1:0] filtered,
    input logic                       cfg_ready
);
    import bqlp_pkg::*;

    // a stalled result request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(filtered))
        else $error("stalled result changed or dropped");

    // every accepted sample leads to a valid result request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("result missing after accepted sample");

    // an empty result register never blocks the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with result register empty");

    // channels out of range give zero
    a_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (32'(out_channel) >= CHANNELS) |-> filtered == '0)
        else $error("nonzero result on out-of-range channel");

    // coefficient writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration write refused");
endmodule

bind biquad_lowpass_multichannel bqlp_checker #(
    .CHANNELS (CHANNELS)
) u_bqlp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (smp.valid),
    .in_ready    (smp.ready),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .out_channel (res.out_channel),
    .filtered    (res.filtered),
    .cfg_ready   (cfg.ready)
);
